// File: rtl/page_translate_clock_replace_core_macros.svh
// Assertion macros shared by the checker.
`ifndef PAGE_TRANSLATE_CLOCK_REPLACE_CORE_MACROS_SVH
`define PAGE_TRANSLATE_CLOCK_REPLACE_CORE_MACROS_SVH
// Implication checked every clock, quiet during reset.
`define PTCR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked every clock, also during reset.
`define PTCR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/ptcr_pkg.sv
package ptcr_pkg;
   localparam int FRAMES_DEF    = 128;
   localparam int PAGE_BITS_DEF = 8;
   localparam int OFFSET_BITS   = 8;
   localparam int ADDR_BITS     = 16;
   localparam int FRAME_W       = 7;
   localparam int PADDR_W       = 15;
   localparam int VICTIM_W      = 8;
   localparam int SCAN_PASSES   = 4;
   localparam int LAST_PASS     = 3;

   // Controller -> datapath commands.
   typedef struct packed {
      logic load;        // capture request
      logic lookup;      // read page entry
      logic free_step;   // examine free-search frame
      logic scan_rd;     // read owner of scanned frame
      logic scan_step;   // examine scanned page
      logic commit;      // apply the update, build result
   } cmd_type;

   // Datapath -> controller status.
   typedef struct packed {
      logic hit;
      logic free_found;
      logic free_done;
      logic victim_found;
   } sts_type;
endpackage

// File: rtl/ptcr_ctrl.sv
module ptcr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output ptcr_pkg::cmd_type cmd,
   input  ptcr_pkg::sts_type sts
);
   import ptcr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOKUP = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_FREE   = 3'd3;
   localparam logic [2:0] S_SCANRD = 3'd4;
   localparam logic [2:0] S_SCAN   = 3'd5;
   localparam logic [2:0] S_COMMIT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.hit) state_in = S_COMMIT;
            else         state_in = S_FREE;
         end
         S_FREE: begin
            cmd.free_step = 1'b1;
            if (sts.free_found)     state_in = S_COMMIT;
            else if (sts.free_done) state_in = S_SCANRD;
         end
         S_SCANRD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.victim_found) state_in = S_COMMIT;
            else                  state_in = S_SCANRD;
         end
         S_COMMIT: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule

// File: rtl/ptcr_datapath.sv
module ptcr_datapath #(
   parameter int FRAMES    = ptcr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = ptcr_pkg::PAGE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ptcr_pkg::cmd_type           cmd,
   output ptcr_pkg::sts_type           sts,
   input  logic                        req_op_in,
   input  logic [15:0]                 req_addr_in,
   output logic [ptcr_pkg::FRAME_W-1:0]  frame_out,
   output logic [ptcr_pkg::PADDR_W-1:0]  paddr_out,
   output logic                        fault_out,
   output logic                        evicted_out,
   output logic [ptcr_pkg::VICTIM_W-1:0] victim_out,
   output logic                        wb_out
);
   import ptcr_pkg::*;

   localparam int PAGES = 1 << PAGE_BITS;
   localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW    = $clog2(FRAMES + 1);

   // Page table memory (frame numbers) and frame owner memory.
   logic [FW-1:0]        page_frame_mem [PAGES];
   logic [PAGE_BITS-1:0] frame_owner_mem [FRAMES];
   // Per-entry status bits, reset at once.
   logic [PAGES-1:0]     valid_ff, ref_ff, dirty_ff;
   logic [FRAMES-1:0]    used_ff;
   logic [FW-1:0]        hand_ff;

   logic                 write_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [FW-1:0]        pf_rd_ff;
   logic                 hit_ff;
   logic [CW-1:0]        cnt_ff;
   logic [1:0]           pass_ff;
   logic [FW-1:0]        scan_ff;
   logic [PAGE_BITS-1:0] owner_rd_ff;
   logic [FW-1:0]        sel_frame_ff;
   logic                 evict_ff;
   logic [PAGE_BITS-1:0] vict_ff;
   logic                 vict_dirty_ff;

   logic [FW-1:0] free_idx;
   logic          last_pass;
   logic          accept;
   logic [FW-1:0] hand_next;
   logic [FW-1:0] scan_next;

   assign free_idx  = cnt_ff[FW-1:0];
   assign last_pass = (pass_ff == 2'(LAST_PASS));
   assign accept    = !ref_ff[owner_rd_ff] && (!dirty_ff[owner_rd_ff] || last_pass);
   assign hand_next = (hand_ff == FW'(FRAMES - 1)) ? '0 : hand_ff + 1'b1;
   assign scan_next = (scan_ff == FW'(FRAMES - 1)) ? '0 : scan_ff + 1'b1;

   assign sts.hit          = hit_ff;
   assign sts.free_found   = cmd.free_step && (cnt_ff < CW'(FRAMES)) && !used_ff[free_idx];
   assign sts.free_done    = (cnt_ff >= CW'(FRAMES - 1));
   assign sts.victim_found = cmd.scan_step && accept;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         write_ff  <= req_op_in;
         page_ff   <= req_addr_in[OFFSET_BITS +: PAGE_BITS];
         offset_ff <= req_addr_in[OFFSET_BITS-1:0];
      end
      if (cmd.lookup) begin
         pf_rd_ff <= page_frame_mem[page_ff];
         hit_ff   <= valid_ff[page_ff];
      end
      if (cmd.scan_rd) owner_rd_ff <= frame_owner_mem[scan_ff];
      if (cmd.commit && !hit_ff) begin
         page_frame_mem[page_ff]       <= sel_frame_ff;
         frame_owner_mem[sel_frame_ff] <= page_ff;
      end
      if (cmd.commit) begin
         frame_out   <= FRAME_W'(hit_ff ? pf_rd_ff : sel_frame_ff);
         paddr_out   <= PADDR_W'({(hit_ff ? pf_rd_ff : sel_frame_ff), offset_ff});
         fault_out   <= !hit_ff;
         evicted_out <= !hit_ff && evict_ff;
         victim_out  <= (!hit_ff && evict_ff) ? VICTIM_W'(vict_ff) : '0;
         wb_out      <= !hit_ff && evict_ff && vict_dirty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ref_ff   <= '0;
         dirty_ff <= '0;
         used_ff  <= '0;
         hand_ff  <= '0;
         cnt_ff   <= '0;
         pass_ff  <= '0;
         scan_ff  <= '0;
         evict_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            cnt_ff   <= '0;
            pass_ff  <= '0;
            scan_ff  <= hand_ff;
            evict_ff <= 1'b0;
         end
         if (cmd.free_step) begin
            if (sts.free_found) sel_frame_ff <= free_idx;
            if (sts.free_done && !sts.free_found) cnt_ff <= '0;
            else                                  cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.scan_step) begin
            if (accept) begin
               sel_frame_ff  <= scan_ff;
               evict_ff      <= 1'b1;
               vict_ff       <= owner_rd_ff;
               vict_dirty_ff <= dirty_ff[owner_rd_ff];
               // Advance the hand one frame from where the scan started.
               hand_ff       <= hand_next;
            end else begin
               ref_ff[owner_rd_ff] <= 1'b0;
               scan_ff             <= scan_next;
               if (cnt_ff == CW'(FRAMES - 1)) begin
                  cnt_ff  <= '0;
                  pass_ff <= pass_ff + 1'b1;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
         end
         if (cmd.commit) begin
            if (!hit_ff) begin
               if (evict_ff) valid_ff[vict_ff] <= 1'b0;
               valid_ff[page_ff]     <= 1'b1;
               dirty_ff[page_ff]     <= write_ff;
               used_ff[sel_frame_ff] <= 1'b1;
            end else if (write_ff) begin
               dirty_ff[page_ff] <= 1'b1;
            end
            ref_ff[page_ff] <= 1'b1;
         end
      end
   end
endmodule

// File: rtl/page_translate_clock_replace_core.sv
// Demand-paged translation with an enhanced second-chance clock. Each request
// is one access; each gives one response. A hit goes through capture,
// page-table read, decide and commit; the response is registered at commit
// and the next request is taken back in idle. A fault with a free frame
// searches the frames lowest first and stops at the lowest free frame. With
// all frames in use, the free search examines all FRAMES frames, then the
// clock scan reads the owner memory and then tests the status of each frame
// examined, at most 3 * FRAMES + 1 frames since the fourth pass takes its
// first frame; the single read port of the frame owner memory sets this
// split. The scan starts at the hand, and on a victim the hand advances
// exactly one frame from its start. One access is in flight at a time; a
// finished response waits in the output register while the next request is
// taken, and commit holds while that register is full and not being taken.
module page_translate_clock_replace_core #(
   parameter int FRAMES    = ptcr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = ptcr_pkg::PAGE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // logical_address[15:0]
   input  logic        req_tuser,   // op (1 write)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // frame[6:0], phys_addr[21:7], page_fault[22], evicted[23],
   // victim_page[31:24], write_back[32], zero fill
   output logic [39:0] rsp_tdata
);
   import ptcr_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [FRAME_W-1:0]  frame;
   logic [PADDR_W-1:0]  paddr;
   logic                fault, evicted, wb;
   logic [VICTIM_W-1:0] victim;

   ptcr_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .sts
   );

   ptcr_datapath #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_op_in    (req_tuser),
      .req_addr_in  (req_tdata),
      .frame_out    (frame),
      .paddr_out    (paddr),
      .fault_out    (fault),
      .evicted_out  (evicted),
      .victim_out   (victim),
      .wb_out       (wb)
   );

   assign rsp_tdata = {7'b0, wb, victim, evicted, fault, paddr, frame};
endmodule

// File: rtl/ptcr_checker.sv
`include "page_translate_clock_replace_core_macros.svh"
module ptcr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   `PTCR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid,
      "rsp dropped")
   `PTCR_ASSERT(a_evict_fault, clock, reset, rsp_tvalid && rsp_tdata[23] |-> rsp_tdata[22],
      "evict without fault")
   `PTCR_ASSERT(a_req_busy, clock, reset, req_tvalid && req_tready |=> !req_tready,
      "request taken while busy")
   `PTCR_ASSERT(a_paddr, clock, reset, rsp_tvalid |-> rsp_tdata[21:15] == rsp_tdata[6:0],
      "paddr frame mismatch")
   `PTCR_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "rsp valid after reset")
endmodule

bind page_translate_clock_replace_core ptcr_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

// File: bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ptcr_pkg::*;

   localparam int FRAME_COUNT = FRAMES_DEF;
   localparam int PAGE_COUNT  = 1 << PAGE_BITS_DEF;
   localparam bit OP_READ    = 1'b0;
   localparam bit OP_WRITE   = 1'b1;
   localparam int CYCLE_LIMIT = 5_000_000;

   typedef struct packed {
      logic                write_back;
      logic [VICTIM_W-1:0] victim;
      logic                evicted;
      logic                fault;
      logic [PADDR_W-1:0]  paddr;
      logic [FRAME_W-1:0]  frame;
   } xlat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   page_translate_clock_replace_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // Shadow page table and clock state.
   bit                 pt_valid [PAGE_COUNT];
   bit [FRAME_W-1:0]   pt_frame [PAGE_COUNT];
   bit                 pt_ref   [PAGE_COUNT];
   bit                 pt_clean [PAGE_COUNT];
   bit                 fr_used  [FRAME_COUNT];
   bit [7:0]           fr_owner [FRAME_COUNT];
   int                 hand;

   xlat_type pending_xlat[$];
   int     error_count = 0;
   int     cycle_count = 0;
   bit     hold_rsp = 0;   // long receiver hold-off
   bit     quiet = 0;      // no random idling
   bit     dense_pages = 0;

   initial forever #10 clock = ~clock;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Enhanced second-chance victim search.
   function automatic int clock_victim();
      int f, p;
      for (int pass = 0; pass < SCAN_PASSES; pass++)
         for (int k = 0; k < FRAME_COUNT; k++) begin
            f = (hand + k) % FRAME_COUNT;
            p = fr_owner[f];
            if (!pt_ref[p] && (pt_clean[p] || pass == LAST_PASS)) begin
               hand = (hand + 1) % FRAME_COUNT;
               return f;
            end
            pt_ref[p] = 0;
         end
      return 0;
   endfunction

   function automatic xlat_type translate(input bit op, input logic [15:0] addr);
      xlat_type r;
      int page, f;
      bit found;
      page = addr[15:8];
      r = '0;
      found = 0;
      f = 0;
      if (pt_valid[page]) begin
         f = pt_frame[page];
      end else begin
         r.fault = 1;
         for (int i = 0; i < FRAME_COUNT && !found; i++)
            if (!fr_used[i]) begin
               f = i;
               found = 1;
            end
         if (!found) begin
            f = clock_victim();
            r.evicted = 1;
            r.victim = fr_owner[f];
            r.write_back = !pt_clean[fr_owner[f]];
            pt_valid[fr_owner[f]] = 0;
         end
         pt_valid[page] = 1;
         pt_frame[page] = FRAME_W'(f);
         pt_clean[page] = 1;
         fr_used[f] = 1;
         fr_owner[f] = 8'(page);
      end
      pt_ref[page] = 1;
      if (op == OP_WRITE) pt_clean[page] = 0;
      r.frame = FRAME_W'(f);
      r.paddr = {f[FRAME_W-1:0], addr[7:0]};
      return r;
   endfunction

   // Offer one access; hold it until the transfer and log the expectation.
   task automatic send_access(input bit op, input logic [15:0] addr);
      while (!quiet && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= addr;
      do @(posedge clock); while (!req_tready);
      pending_xlat.push_back(translate(op, addr));
      @(negedge clock);
   endtask

   // Receiver: random stalls, sample at the rising edge.
   always @(negedge clock)
      rsp_tready <= !hold_rsp && (quiet || $urandom_range(99) >= 8);

   always @(posedge clock) begin
      xlat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[32:0];
         if (pending_xlat.size() == 0) begin
            report("unexpected transfer", 1, 0);
         end else begin
            want = pending_xlat.pop_front();
            if (got.frame != want.frame) report("frame", got.frame, want.frame);
            if (got.paddr != want.paddr) report("phys_addr", got.paddr, want.paddr);
            if (got.fault != want.fault) report("page_fault", got.fault, want.fault);
            if (got.evicted != want.evicted) report("evicted", got.evicted, want.evicted);
            if (got.victim != want.victim) report("victim_page", got.victim, want.victim);
            if (got.write_back != want.write_back)
               report("write_back", got.write_back, want.write_back);
         end
      end
   end

   // Watchdog: every fault may search 128 frames, then scan 3*128+1 frames,
   // each read and then tested, plus stalls.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_xlat.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_addr();
      logic [7:0] page;
      page = dense_pages ? 8'($urandom_range(159)) : 8'($urandom);
      return {page, 8'($urandom)};
   endfunction

   // Extremes, hits, read and write.
   task automatic test_directed();
      send_access(OP_READ, 16'h0000);
      send_access(OP_WRITE, 16'hFFFF);
      send_access(OP_READ, 16'hFF00);
      send_access(OP_WRITE, 16'h00FF);
      send_access(OP_READ, 16'h5AA5);
      send_access(OP_WRITE, 16'hA55A);
      send_access(OP_READ, 16'h0180);
      wait_drain();
   endtask

   // Fill every frame so later faults must run the clock.
   task automatic test_fill_frames();
      quiet = 1;
      for (int p = 2; p < 140; p++)
         send_access(p[0] ? OP_WRITE : OP_READ, {p[7:0], 8'($urandom)});
      quiet = 0;
      wait_drain();
   endtask

   // Receiver stalls long while requests keep coming; the block must back up.
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 20; i++) send_access(1'($urandom), rand_addr());
      join
      wait_drain();
   endtask

   // Random accesses with a hot working set, all pages, and quiet stretches.
   task automatic test_random();
      for (int i = 0; i < 700; i++) begin
         quiet = (i >= 300 && i < 400);
         dense_pages = (i % 200) < 120;
         send_access(1'($urandom), rand_addr());
      end
      quiet = 0;
      wait_drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_fill_frames();
      test_backpressure();
      test_random();
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
